### hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Operation codes, fixed widths and part saturation helpers for the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CMD_W  = 3;
    localparam int PART_W = 16;
    localparam int QUO_W  = 16;
    localparam int D_W    = 32;
    localparam int CLIP_W = 34;

    localparam logic [CMD_W-1:0] OP_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] OP_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] OP_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] OP_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] OP_CONJ = 3'd4;

    localparam logic signed [PART_W-1:0] PART_MAX = 16'sh7FFF;
    localparam logic signed [PART_W-1:0] PART_MIN = 16'sh8000;
    localparam logic [QUO_W-1:0]         POS_LIM  = 16'd32767;
    localparam logic [QUO_W-1:0]         NEG_LIM  = 16'd32768;

    typedef struct packed {
        logic signed [PART_W-1:0] val;
        logic                     sat;
    } t_part;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic                     dz;
        logic                     ovf_re;
        logic                     ovf_im;
        logic                     neg_re;
        logic                     neg_im;
        logic signed [PART_W-1:0] dir_re;
        logic signed [PART_W-1:0] dir_im;
        logic                     dir_sat;
    } t_ctrl;

    function automatic t_part clip_part(input logic signed [CLIP_W-1:0] v);
        t_part r;
        if (v > CLIP_W'(PART_MAX)) begin
            r.val = PART_MAX;
            r.sat = 1'b1;
        end else if (v < CLIP_W'(PART_MIN)) begin
            r.val = PART_MIN;
            r.sat = 1'b1;
        end else begin
            r.val = PART_W'(v);
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic t_part div_part(input logic ovf, input logic neg,
                                       input logic [QUO_W-1:0] q);
        t_part r;
        if (!neg) begin
            if (ovf || q > POS_LIM) begin
                r.val = PART_MAX;
                r.sat = 1'b1;
            end else begin
                r.val = signed'(q);
                r.sat = 1'b0;
            end
        end else begin
            if (ovf || q > NEG_LIM) begin
                r.val = PART_MIN;
                r.sat = 1'b1;
            end else begin
                r.val = signed'(PART_W'(17'd0 - 17'(q)));
                r.sat = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

### hdl/cau_prod.sv
// ----------------------------------------------------------------------------
// cau_prod
// Two register stages: partial products, then the complex sums, the divide
// numerators and the squared magnitude of the divisor.
// ----------------------------------------------------------------------------
module cau_prod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [cau_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [cau_pkg::PART_W-1:0] i_a_re,
    input  logic signed [cau_pkg::PART_W-1:0] i_a_im,
    input  logic signed [cau_pkg::PART_W-1:0] i_b_re,
    input  logic signed [cau_pkg::PART_W-1:0] i_b_im,
    output logic                              o_valid,
    output logic [cau_pkg::CMD_W-1:0]         o_cmd,
    output logic signed [cau_pkg::PART_W-1:0] o_a_re,
    output logic signed [cau_pkg::PART_W-1:0] o_a_im,
    output logic signed [cau_pkg::PART_W-1:0] o_b_re,
    output logic signed [cau_pkg::PART_W-1:0] o_b_im,
    output logic signed [32:0]                o_mul_re,
    output logic signed [32:0]                o_mul_im,
    output logic signed [32:0]                o_num_re,
    output logic signed [32:0]                o_num_im,
    output logic [cau_pkg::D_W-1:0]           o_den
);

    logic                              r_vld1;
    logic                              r_vld2;
    logic [cau_pkg::CMD_W-1:0]         r_cmd1;
    logic [cau_pkg::CMD_W-1:0]         r_cmd2;
    logic signed [cau_pkg::PART_W-1:0] r_a_re1, r_a_im1, r_b_re1, r_b_im1;
    logic signed [cau_pkg::PART_W-1:0] r_a_re2, r_a_im2, r_b_re2, r_b_im2;
    logic signed [31:0]                r_rr, r_ii, r_ir, r_ri;
    logic [31:0]                       r_br2, r_bi2;
    logic signed [32:0]                r_mul_re, r_mul_im, r_num_re, r_num_im;
    logic [cau_pkg::D_W-1:0]           r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd1  <= i_cmd;
            r_a_re1 <= i_a_re;
            r_a_im1 <= i_a_im;
            r_b_re1 <= i_b_re;
            r_b_im1 <= i_b_im;
            r_rr    <= i_a_re * i_b_re;
            r_ii    <= i_a_im * i_b_im;
            r_ir    <= i_a_im * i_b_re;
            r_ri    <= i_a_re * i_b_im;
            r_br2   <= unsigned'(32'(i_b_re) * 32'(i_b_re));
            r_bi2   <= unsigned'(32'(i_b_im) * 32'(i_b_im));

            r_cmd2   <= r_cmd1;
            r_a_re2  <= r_a_re1;
            r_a_im2  <= r_a_im1;
            r_b_re2  <= r_b_re1;
            r_b_im2  <= r_b_im1;
            r_mul_re <= 33'(r_rr) - 33'(r_ii);
            r_mul_im <= 33'(r_ir) + 33'(r_ri);
            r_num_re <= 33'(r_rr) + 33'(r_ii);
            r_num_im <= 33'(r_ir) - 33'(r_ri);
            r_den    <= r_br2 + r_bi2;
        end
    end

    assign o_valid  = r_vld2;
    assign o_cmd    = r_cmd2;
    assign o_a_re   = r_a_re2;
    assign o_a_im   = r_a_im2;
    assign o_b_re   = r_b_re2;
    assign o_b_im   = r_b_im2;
    assign o_mul_re = r_mul_re;
    assign o_mul_im = r_mul_im;
    assign o_num_re = r_num_re;
    assign o_num_im = r_num_im;
    assign o_den    = r_den;

endmodule

### hdl/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring divide stage: resolves one quotient bit of both parts.
// ----------------------------------------------------------------------------
module cau_div_step #(
    parameter int REM_W = 48,
    parameter int SHIFT = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  cau_pkg::t_ctrl                 i_ctrl,
    input  logic [cau_pkg::D_W-1:0]        i_den,
    input  logic [REM_W-1:0]               i_rem_re,
    input  logic [REM_W-1:0]               i_rem_im,
    input  logic [cau_pkg::QUO_W-1:0]      i_q_re,
    input  logic [cau_pkg::QUO_W-1:0]      i_q_im,
    output logic                           o_valid,
    output cau_pkg::t_ctrl                 o_ctrl,
    output logic [cau_pkg::D_W-1:0]        o_den,
    output logic [REM_W-1:0]               o_rem_re,
    output logic [REM_W-1:0]               o_rem_im,
    output logic [cau_pkg::QUO_W-1:0]      o_q_re,
    output logic [cau_pkg::QUO_W-1:0]      o_q_im
);

    logic [REM_W-1:0]          w_trial;
    logic                      w_ge_re, w_ge_im;
    logic                      r_vld;
    cau_pkg::t_ctrl            r_ctrl;
    logic [cau_pkg::D_W-1:0]   r_den;
    logic [REM_W-1:0]          r_rem_re, r_rem_im;
    logic [cau_pkg::QUO_W-1:0] r_q_re, r_q_im;

    assign w_trial = REM_W'(i_den) << SHIFT;
    assign w_ge_re = i_rem_re >= w_trial;
    assign w_ge_im = i_rem_im >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl   <= i_ctrl;
            r_den    <= i_den;
            r_rem_re <= w_ge_re ? i_rem_re - w_trial : i_rem_re;
            r_rem_im <= w_ge_im ? i_rem_im - w_trial : i_rem_im;
            r_q_re   <= i_q_re | (cau_pkg::QUO_W'(w_ge_re) << SHIFT);
            r_q_im   <= i_q_im | (cau_pkg::QUO_W'(w_ge_im) << SHIFT);
        end
    end

    assign o_valid  = r_vld;
    assign o_ctrl   = r_ctrl;
    assign o_den    = r_den;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;

endmodule

### hdl/complex_arith_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_core: cau_prod, operand, divide step and output registers.
// One item per cycle; a stalled output freezes the whole pipeline in place.
// Synchronous active-low reset clears all valid bits; no other state.
// ----------------------------------------------------------------------------
module complex_arith_unit_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cau_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [cau_pkg::PART_W-1:0] i_a_re,
    input  logic signed [cau_pkg::PART_W-1:0] i_a_im,
    input  logic signed [cau_pkg::PART_W-1:0] i_b_re,
    input  logic signed [cau_pkg::PART_W-1:0] i_b_im,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [cau_pkg::PART_W-1:0] o_res_re,
    output logic signed [cau_pkg::PART_W-1:0] o_res_im,
    output logic                              o_saturated,
    output logic                              o_div_zero
);

    localparam int QW    = cau_pkg::QUO_W;
    localparam int REM_W = cau_pkg::D_W + QW;
    localparam logic signed [32:0] MUL_BIAS = 33'((1 << FRAC_BITS) - 1);

    logic                              w_en;
    logic                              p_vld;
    logic [cau_pkg::CMD_W-1:0]         p_cmd;
    logic signed [cau_pkg::PART_W-1:0] p_a_re, p_a_im, p_b_re, p_b_im;
    logic signed [32:0]                p_mul_re, p_mul_im, p_num_re, p_num_im;
    logic [cau_pkg::D_W-1:0]           p_den;

    logic signed [32:0]                w_msc_re, w_msc_im;
    logic signed [cau_pkg::CLIP_W-1:0] w_dir_re, w_dir_im;
    cau_pkg::t_part                    w_cl_re, w_cl_im;
    logic                              w_neg_re, w_neg_im;
    logic [31:0]                       w_abs_re, w_abs_im;
    logic [REM_W-1:0]                  w_n_re, w_n_im, w_dlim;
    cau_pkg::t_ctrl                    n_ctrl;

    logic [QW:0]                       w_vld;
    cau_pkg::t_ctrl                    w_ctrl [QW+1];
    logic [cau_pkg::D_W-1:0]           w_den  [QW+1];
    logic [REM_W-1:0]                  w_rem_re [QW+1];
    logic [REM_W-1:0]                  w_rem_im [QW+1];
    logic [QW-1:0]                     w_q_re [QW+1];
    logic [QW-1:0]                     w_q_im [QW+1];

    logic                              r_s3_vld;
    cau_pkg::t_ctrl                    r_s3_ctrl;
    logic [cau_pkg::D_W-1:0]           r_s3_den;
    logic [REM_W-1:0]                  r_s3_n_re, r_s3_n_im;

    cau_pkg::t_part                    w_dv_re, w_dv_im;
    cau_pkg::t_ctrl                    w_fin;
    logic                              r_out_vld;
    logic signed [cau_pkg::PART_W-1:0] r_res_re, r_res_im;
    logic                              r_sat, r_dz;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;

    cau_prod u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_valid  (p_vld),
        .o_cmd    (p_cmd),
        .o_a_re   (p_a_re),
        .o_a_im   (p_a_im),
        .o_b_re   (p_b_re),
        .o_b_im   (p_b_im),
        .o_mul_re (p_mul_re),
        .o_mul_im (p_mul_im),
        .o_num_re (p_num_re),
        .o_num_im (p_num_im),
        .o_den    (p_den)
    );

    assign w_msc_re = (p_mul_re + (p_mul_re[32] ? MUL_BIAS : 33'sd0)) >>> FRAC_BITS;
    assign w_msc_im = (p_mul_im + (p_mul_im[32] ? MUL_BIAS : 33'sd0)) >>> FRAC_BITS;

    always_comb begin
        unique case (p_cmd)
            cau_pkg::OP_ADD: begin
                w_dir_re = 34'(p_a_re) + 34'(p_b_re);
                w_dir_im = 34'(p_a_im) + 34'(p_b_im);
            end
            cau_pkg::OP_SUB: begin
                w_dir_re = 34'(p_a_re) - 34'(p_b_re);
                w_dir_im = 34'(p_a_im) - 34'(p_b_im);
            end
            cau_pkg::OP_MUL: begin
                w_dir_re = 34'(w_msc_re);
                w_dir_im = 34'(w_msc_im);
            end
            cau_pkg::OP_CONJ: begin
                w_dir_re = 34'(p_a_re);
                w_dir_im = 34'sd0 - 34'(p_a_im);
            end
            default: begin
                w_dir_re = '0;
                w_dir_im = '0;
            end
        endcase
    end

    assign w_cl_re  = cau_pkg::clip_part(w_dir_re);
    assign w_cl_im  = cau_pkg::clip_part(w_dir_im);
    assign w_neg_re = p_num_re[32];
    assign w_neg_im = p_num_im[32];
    assign w_abs_re = 32'(w_neg_re ? -p_num_re : p_num_re);
    assign w_abs_im = 32'(w_neg_im ? -p_num_im : p_num_im);
    assign w_n_re   = REM_W'(w_abs_re) << FRAC_BITS;
    assign w_n_im   = REM_W'(w_abs_im) << FRAC_BITS;
    assign w_dlim   = REM_W'(p_den) << QW;

    always_comb begin
        n_ctrl.cmd     = p_cmd;
        n_ctrl.dz      = (p_den == '0);
        n_ctrl.ovf_re  = (w_n_re >= w_dlim);
        n_ctrl.ovf_im  = (w_n_im >= w_dlim);
        n_ctrl.neg_re  = w_neg_re;
        n_ctrl.neg_im  = w_neg_im;
        n_ctrl.dir_re  = w_cl_re.val;
        n_ctrl.dir_im  = w_cl_im.val;
        n_ctrl.dir_sat = w_cl_re.sat || w_cl_im.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_ctrl <= n_ctrl;
            r_s3_den  <= p_den;
            r_s3_n_re <= w_n_re;
            r_s3_n_im <= w_n_im;
        end
    end

    assign w_vld[0]    = r_s3_vld;
    assign w_ctrl[0]   = r_s3_ctrl;
    assign w_den[0]    = r_s3_den;
    assign w_rem_re[0] = r_s3_n_re;
    assign w_rem_im[0] = r_s3_n_im;
    assign w_q_re[0]   = '0;
    assign w_q_im[0]   = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        cau_div_step #(
            .REM_W (REM_W),
            .SHIFT (QW - 1 - g)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_vld[g]),
            .i_ctrl   (w_ctrl[g]),
            .i_den    (w_den[g]),
            .i_rem_re (w_rem_re[g]),
            .i_rem_im (w_rem_im[g]),
            .i_q_re   (w_q_re[g]),
            .i_q_im   (w_q_im[g]),
            .o_valid  (w_vld[g+1]),
            .o_ctrl   (w_ctrl[g+1]),
            .o_den    (w_den[g+1]),
            .o_rem_re (w_rem_re[g+1]),
            .o_rem_im (w_rem_im[g+1]),
            .o_q_re   (w_q_re[g+1]),
            .o_q_im   (w_q_im[g+1])
        );
    end

    assign w_fin   = w_ctrl[QW];
    assign w_dv_re = cau_pkg::div_part(w_fin.ovf_re, w_fin.neg_re, w_q_re[QW]);
    assign w_dv_im = cau_pkg::div_part(w_fin.ovf_im, w_fin.neg_im, w_q_im[QW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_fin.cmd == cau_pkg::OP_DIV && w_fin.dz) begin
                r_res_re <= '0;
                r_res_im <= '0;
                r_sat    <= 1'b0;
                r_dz     <= 1'b1;
            end else if (w_fin.cmd == cau_pkg::OP_DIV) begin
                r_res_re <= w_dv_re.val;
                r_res_im <= w_dv_im.val;
                r_sat    <= w_dv_re.sat || w_dv_im.sat;
                r_dz     <= 1'b0;
            end else begin
                r_res_re <= w_fin.dir_re;
                r_res_im <= w_fin.dir_im;
                r_sat    <= w_fin.dir_sat;
                r_dz     <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_res_re    = r_res_re;
    assign o_res_im    = r_res_im;
    assign o_saturated = r_sat;
    assign o_div_zero  = r_dz;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_re == '0 && o_res_im == '0 && !o_saturated)
        else $error("divide by zero result not cleared");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_res_re == cau_pkg::PART_MAX || o_res_re == cau_pkg::PART_MIN ||
            o_res_im == cau_pkg::PART_MAX || o_res_im == cau_pkg::PART_MIN)
        else $error("saturation flag without clipped part");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_vld) && $stable(r_s3_vld))
        else $error("pipeline advanced while stalled");
`endif

endmodule
